// ----- rtl/core/mte_pkg.sv -----
package mte_pkg;

   // Fixed field widths
   localparam int SAMPLE_W    = 16;
   localparam int DELAY_W     = 14;
   localparam int COUNT_W     = 4;
   localparam int GAIN_W      = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DELAY_SAMPLES = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ECHO_COUNT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ECHO_GAIN     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEREO        = 2'd3;

   // Register reset values
   localparam logic [DELAY_W-1:0] DELAY_RESET  = 14'd4410;
   localparam logic [COUNT_W-1:0] COUNT_RESET  = 4'd3;
   localparam logic [GAIN_W-1:0]  GAIN_RESET   = 16'd16384;
   localparam logic               STEREO_RESET = 1'b1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_in;
      logic signed [SAMPLE_W-1:0] right_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
   } rsp_type;

   // Microprogram steps
   localparam int PC_W = 3;
   localparam logic [PC_W-1:0] PC_IDLE      = 3'd0;
   localparam logic [PC_W-1:0] PC_READ      = 3'd1;
   localparam logic [PC_W-1:0] PC_MUL_LEFT  = 3'd2;
   localparam logic [PC_W-1:0] PC_ACC_LEFT  = 3'd3;
   localparam logic [PC_W-1:0] PC_ACC_RIGHT = 3'd4;
   localparam logic [PC_W-1:0] PC_POWER     = 3'd5;
   localparam logic [PC_W-1:0] PC_EMIT      = 3'd6;
   localparam logic [PC_W-1:0] PC_LAST      = PC_EMIT;

   // Multiplier operand select
   localparam logic [1:0] MUL_NONE  = 2'd0;
   localparam logic [1:0] MUL_LEFT  = 2'd1;
   localparam logic [1:0] MUL_RIGHT = 2'd2;
   localparam logic [1:0] MUL_GAIN  = 2'd3;

   // Accumulator select
   localparam logic [1:0] ACC_NONE  = 2'd0;
   localparam logic [1:0] ACC_LEFT  = 2'd1;
   localparam logic [1:0] ACC_RIGHT = 2'd2;

   // Jump conditions
   localparam logic [2:0] JMP_NEVER     = 3'd0;
   localparam logic [2:0] JMP_ALWAYS    = 3'd1;
   localparam logic [2:0] JMP_NO_ITEM   = 3'd2;
   localparam logic [2:0] JMP_TAPS_DONE = 3'd3;
   localparam logic [2:0] JMP_OUT_BUSY  = 3'd4;

   typedef struct packed {
      logic            accept;
      logic            mem_read;
      logic [1:0]      mul_sel;
      logic [1:0]      acc_sel;
      logic            power_step;
      logic            emit;
      logic [2:0]      jump_cond;
      logic [PC_W-1:0] jump_to;
   } ctl_word_type;

   typedef struct packed {
      logic item_taken;
      logic taps_done;
      logic out_busy;
   } seq_stat_type;

endpackage

// ----- rtl/core/multitap_echo_core.sv -----
// Stereo multi-tap echo. Each accepted item carries one left and one right Q1.15
// sample; the block writes it into a per-channel delay line of LINE_DEPTH entries
// and returns one item holding the input plus up to MAX_TAPS echoes, tap j taken
// (j+1)*delay_samples items back and weighted by echo_gain to the power j, rounded
// and saturated to 16 bits. Taps past the end of the line read its oldest entry.
// With stereo at 0 the right sample passes straight through. For each item a small
// microprogram drives one shared 33x17 multiplier three times per tap (left echo,
// right echo, next gain power) behind one read of each delay-line memory. The
// result sits in an output register, so the next item is taken while it waits.
// After reset the delay lines are cleared one entry per cycle, during which
// req_stall stays high; configuration writes are taken throughout. Write
// configuration only while the block is idle.
module multitap_echo_core
   import mte_pkg::*;
#(
   parameter int LINE_DEPTH = 16384,
   parameter int MAX_TAPS   = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // input items
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_item,
   // result items
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_item,
   // configuration
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int DW    = ((AW > DELAY_W) ? AW : DELAY_W) + 1;
   localparam int TW    = $clog2(MAX_TAPS + 1);
   localparam int CW    = (TW > COUNT_W) ? TW : COUNT_W;
   localparam int ACC_W = 50 + $clog2(MAX_TAPS + 1);
   localparam int Q_W   = ACC_W - 15;

   localparam logic [AW-1:0] LAST_ENTRY = AW'(LINE_DEPTH - 1);
   localparam logic [AW:0]   DEPTH_V    = (AW + 1)'(LINE_DEPTH);
   localparam logic [CW-1:0] TAPS_MAX_V = CW'(MAX_TAPS);
   localparam logic signed [Q_W-1:0] Q_MAX = 32767;
   localparam logic signed [Q_W-1:0] Q_MIN = -32768;

   // Round half up and saturate to Q1.15
   function automatic logic [SAMPLE_W-1:0] finish(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] t;
      logic signed [Q_W-1:0]   q;
      t = acc + $signed(ACC_W'(16384));
      q = t[ACC_W-1:15];
      if (q > Q_MAX) begin
         finish = 16'h7FFF;
      end else if (q < Q_MIN) begin
         finish = 16'h8000;
      end else begin
         finish = q[SAMPLE_W-1:0];
      end
   endfunction

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   ctl_word_type ctl;
   seq_stat_type stat;

   mte_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [DELAY_W-1:0] delay_ff,  delay_in;
   logic [COUNT_W-1:0] count_ff,  count_in;
   logic [GAIN_W-1:0]  gain_ff,   gain_in;
   logic               stereo_ff, stereo_in;

   always_comb begin
      delay_in  = delay_ff;
      count_in  = count_ff;
      gain_in   = gain_ff;
      stereo_in = stereo_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DELAY_SAMPLES: delay_in  = csr_wdata[DELAY_W-1:0];
            CSR_ECHO_COUNT:    count_in  = csr_wdata[COUNT_W-1:0];
            CSR_ECHO_GAIN:     gain_in   = csr_wdata[GAIN_W-1:0];
            CSR_STEREO:        stereo_in = csr_wdata[0];
            default:           delay_in  = delay_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff  <= DELAY_RESET;
         count_ff  <= COUNT_RESET;
         gain_ff   <= GAIN_RESET;
         stereo_ff <= STEREO_RESET;
      end else begin
         delay_ff  <= delay_in;
         count_ff  <= count_in;
         gain_ff   <= gain_in;
         stereo_ff <= stereo_in;
      end
   end

   // ---------------------------------------------------------------
   // Datapath state
   // ---------------------------------------------------------------
   logic                      clear_ff, clear_in;     // clearing pass running
   logic [AW-1:0]             wp_ff, wp_in;           // write pointer, also clear address
   logic [AW-1:0]             dly_ff, dly_in;         // delay of the current tap, clamped
   logic [TW-1:0]             tap_ff, tap_in;
   logic [31:0]               power_ff, power_in;     // gain^j, unsigned Q.15
   logic signed [ACC_W-1:0]   acc_l_ff, acc_l_in;
   logic signed [ACC_W-1:0]   acc_r_ff, acc_r_in;
   logic signed [49:0]        prod_ff, prod_in;
   logic [SAMPLE_W-1:0]       right_pass_ff, right_pass_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic signed [SAMPLE_W-1:0] rd_left_ff;
   logic signed [SAMPLE_W-1:0] rd_right_ff;

   logic                item_taken;
   logic                out_busy;
   logic                emit_go;
   logic [CW-1:0]       taps_eff;
   logic                taps_done;
   logic [DW-1:0]       dly_first;
   logic [DW-1:0]       dly_sum;
   logic [AW-1:0]       dly_first_clamp;
   logic [AW-1:0]       dly_next_clamp;
   logic [AW:0]         rd_wrap;
   logic [AW-1:0]       rd_addr;
   logic signed [32:0]  mul_a;
   logic signed [16:0]  mul_b;
   logic [48:0]         pw_round;
   logic [33:0]         pw_shift;
   logic [31:0]         power_next;
   logic                left_we;
   logic                right_we;
   logic [SAMPLE_W-1:0] left_wdata;
   logic [SAMPLE_W-1:0] right_wdata;

   // Handshake: take an item only at the idle step once the lines are clear
   assign req_stall  = ~ctl.accept | clear_ff;
   assign item_taken = req_valid & ~req_stall;
   assign out_busy   = rsp_valid_ff & rsp_stall;
   assign emit_go    = ctl.emit & ~out_busy;

   // Limit the tap count
   assign taps_eff  = (CW'(count_ff) > TAPS_MAX_V) ? TAPS_MAX_V : CW'(count_ff);
   assign taps_done = (CW'(tap_ff) >= taps_eff);

   assign stat.item_taken = item_taken;
   assign stat.taps_done  = taps_done;
   assign stat.out_busy   = out_busy;

   // Tap delay: first tap at delay_samples, each later one delay_samples further,
   // held at the oldest entry once it runs off the line
   assign dly_first       = DW'(delay_ff);
   assign dly_sum         = DW'(dly_ff) + DW'(delay_ff);
   assign dly_first_clamp = (dly_first > DW'(LAST_ENTRY)) ? LAST_ENTRY
                                                          : dly_first[AW-1:0];
   assign dly_next_clamp  = (dly_sum > DW'(LAST_ENTRY)) ? LAST_ENTRY : dly_sum[AW-1:0];

   // Read address, modulo the line depth
   assign rd_wrap = {1'b0, wp_ff} + DEPTH_V - {1'b0, dly_ff};
   assign rd_addr = (wp_ff >= dly_ff) ? (wp_ff - dly_ff) : rd_wrap[AW-1:0];

   // Shared multiplier: power against a sample or against the gain
   assign mul_a = $signed({1'b0, power_ff});
   always_comb begin
      case (ctl.mul_sel)
         MUL_LEFT:  mul_b = $signed({rd_left_ff[SAMPLE_W-1], rd_left_ff});
         MUL_RIGHT: mul_b = $signed({rd_right_ff[SAMPLE_W-1], rd_right_ff});
         MUL_GAIN:  mul_b = $signed({1'b0, gain_ff});
         default:   mul_b = '0;
      endcase
   end

   // Next gain power: round, drop the fraction, saturate to 32 bits
   assign pw_round   = prod_ff[48:0] + 49'd16384;
   assign pw_shift   = pw_round[48:15];
   assign power_next = (|pw_shift[33:32]) ? 32'hFFFF_FFFF : pw_shift[31:0];

   // Delay-line write port: zeros while clearing, else the accepted samples (right only in stereo)
   assign left_we     = clear_ff | item_taken;
   assign right_we    = clear_ff | (item_taken & stereo_ff);
   assign left_wdata  = clear_ff ? '0 : req_item.left_in;
   assign right_wdata = clear_ff ? '0 : req_item.right_in;

   always_comb begin
      clear_in      = clear_ff;
      wp_in         = wp_ff;
      dly_in        = dly_ff;
      tap_in        = tap_ff;
      power_in      = power_ff;
      acc_l_in      = acc_l_ff;
      acc_r_in      = acc_r_ff;
      prod_in       = prod_ff;
      right_pass_in = right_pass_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;

      // Clearing pass: advance through every entry, then drop the flag
      if (clear_ff) begin
         if (wp_ff == LAST_ENTRY) begin
            wp_in    = '0;
            clear_in = 1'b0;
         end else begin
            wp_in = wp_ff + 1'b1;
         end
      end

      // Load a new item: input scaled by one, power one, first tap
      if (item_taken) begin
         acc_l_in      = $signed({{(ACC_W-31){req_item.left_in[SAMPLE_W-1]}},
                                   req_item.left_in, 15'd0});
         acc_r_in      = $signed({{(ACC_W-31){req_item.right_in[SAMPLE_W-1]}},
                                   req_item.right_in, 15'd0});
         right_pass_in = req_item.right_in;
         power_in      = 32'd32768;
         dly_in        = dly_first_clamp;
         tap_in        = '0;
      end

      if (ctl.mul_sel != MUL_NONE) begin
         prod_in = mul_a * mul_b;
      end

      case (ctl.acc_sel)
         ACC_LEFT: begin
            acc_l_in = acc_l_ff + $signed({{(ACC_W-50){prod_ff[49]}}, prod_ff});
         end
         ACC_RIGHT: begin
            if (stereo_ff) begin
               acc_r_in = acc_r_ff + $signed({{(ACC_W-50){prod_ff[49]}}, prod_ff});
            end
         end
         default: begin
            acc_l_in = acc_l_in;
         end
      endcase

      // Step to the next tap
      if (ctl.power_step) begin
         power_in = power_next;
         dly_in   = dly_next_clamp;
         tap_in   = tap_ff + 1'b1;
      end

      // Release the result when the output register is free
      if (rsp_valid_ff & ~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (emit_go) begin
         rsp_valid_in       = 1'b1;
         rsp_in.left_out    = finish(acc_l_ff);
         rsp_in.right_out   = stereo_ff ? finish(acc_r_ff) : right_pass_ff;
         wp_in              = (wp_ff == LAST_ENTRY) ? '0 : wp_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dly_ff        <= dly_in;
      tap_ff        <= tap_in;
      power_ff      <= power_in;
      acc_l_ff      <= acc_l_in;
      acc_r_ff      <= acc_r_in;
      prod_ff       <= prod_in;
      right_pass_ff <= right_pass_in;
      rsp_ff        <= rsp_in;
   end

   // ---------------------------------------------------------------
   // Delay lines: one write and one registered read per cycle each
   // ---------------------------------------------------------------
   logic [SAMPLE_W-1:0] left_mem  [LINE_DEPTH];
   logic [SAMPLE_W-1:0] right_mem [LINE_DEPTH];

   always_ff @(posedge clock) begin
      if (left_we) begin
         left_mem[wp_ff] <= left_wdata;
      end
      if (ctl.mem_read) begin
         rd_left_ff <= left_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (right_we) begin
         right_mem[wp_ff] <= right_wdata;
      end
      if (ctl.mem_read) begin
         rd_right_ff <= right_mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ----- rtl/core/mte_seq.sv -----
module mte_seq
   import mte_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  seq_stat_type stat,
   output ctl_word_type ctl
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic            jump_taken;

   // Microcode ROM
   always_comb begin
      ctl = '0;
      unique case (pc_ff)
         PC_IDLE: begin
            ctl.accept    = 1'b1;
            ctl.jump_cond = JMP_NO_ITEM;
            ctl.jump_to   = PC_IDLE;
         end
         PC_READ: begin
            ctl.mem_read  = 1'b1;
            ctl.jump_cond = JMP_TAPS_DONE;
            ctl.jump_to   = PC_EMIT;
         end
         PC_MUL_LEFT: begin
            ctl.mul_sel = MUL_LEFT;
         end
         PC_ACC_LEFT: begin
            ctl.acc_sel = ACC_LEFT;
            ctl.mul_sel = MUL_RIGHT;
         end
         PC_ACC_RIGHT: begin
            ctl.acc_sel = ACC_RIGHT;
            ctl.mul_sel = MUL_GAIN;
         end
         PC_POWER: begin
            ctl.power_step = 1'b1;
            ctl.jump_cond  = JMP_ALWAYS;
            ctl.jump_to    = PC_READ;
         end
         PC_EMIT: begin
            ctl.emit      = 1'b1;
            ctl.jump_cond = JMP_OUT_BUSY;
            ctl.jump_to   = PC_EMIT;
         end
         default: begin
            ctl.jump_cond = JMP_ALWAYS;
            ctl.jump_to   = PC_IDLE;
         end
      endcase
   end

   always_comb begin
      unique case (ctl.jump_cond)
         JMP_NEVER:     jump_taken = 1'b0;
         JMP_ALWAYS:    jump_taken = 1'b1;
         JMP_NO_ITEM:   jump_taken = ~stat.item_taken;
         JMP_TAPS_DONE: jump_taken = stat.taps_done;
         JMP_OUT_BUSY:  jump_taken = stat.out_busy;
         default:       jump_taken = 1'b0;
      endcase
   end

   // Fall through wraps from the last step back to idle
   always_comb begin
      if (jump_taken) begin
         pc_in = ctl.jump_to;
      end else if (pc_ff == PC_LAST) begin
         pc_in = PC_IDLE;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ----- tb/sv/tb.sv -----
module tb;
   import mte_pkg::*;

   localparam int LINE_DEPTH    = 16384;
   localparam int MAX_TAPS      = 8;
   // The slowest item runs at eight taps; leave some margin after the last result.
   localparam int SETTLE_CYCLES = 60;
   // Clearing pass plus about 2000 items at 8 taps with both sides idling,
   // taken several times over.
   localparam int CYCLE_LIMIT   = 800000;
   localparam int RANDOM_ITEMS  = 1800;
   localparam int BURST_ITEMS   = 150;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_item = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_item;
   logic          csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Echo predictor state: history of both channels, write position, register copies.
   logic signed [SAMPLE_W-1:0] left_hist  [LINE_DEPTH];
   logic signed [SAMPLE_W-1:0] right_hist [LINE_DEPTH];
   int unsigned   hist_ptr;
   int unsigned   cfg_delay;
   int unsigned   cfg_taps;
   int unsigned   cfg_gain;
   bit            cfg_stereo;

   rsp_type       pending_echoes [$];
   int            error_count = 0;
   int            items_sent  = 0;
   int unsigned   cycle_count = 0;
   bit            send_gaps   = 1'b0;
   bit            sink_stalls = 1'b0;
   int            stall_run   = 0;

   multitap_echo_core #(
      .LINE_DEPTH(LINE_DEPTH),
      .MAX_TAPS  (MAX_TAPS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // Watchdog: give up well beyond the slowest correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("multitap_echo_core verification failed");
         $finish;
      end
   end

   // Round to nearest with ties toward plus infinity, then clip to Q1.15.
   function automatic logic signed [SAMPLE_W-1:0] q15_round_sat(input longint acc);
      longint q;
      q = (acc + 64'sd16384) >>> 15;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[SAMPLE_W-1:0];
   endfunction

   // Write the new item into the history, then sum the taps behind it.
   function automatic rsp_type echo_predict(input req_type it);
      rsp_type            r;
      int unsigned        taps;
      int unsigned        j;
      int unsigned        d;
      int unsigned        pos;
      longint             acc_l;
      longint             acc_r;
      longint unsigned    power;
      left_hist[hist_ptr] = it.left_in;
      if (cfg_stereo)
         right_hist[hist_ptr] = it.right_in;
      taps  = (cfg_taps > MAX_TAPS) ? MAX_TAPS : cfg_taps;
      power = 32768;
      acc_l = longint'(it.left_in) * 64'sd32768;
      acc_r = longint'(it.right_in) * 64'sd32768;
      for (j = 0; j < taps; j++) begin
         d = (j + 1) * cfg_delay;
         // Taps past the end of the line read the oldest entry.
         if (d > LINE_DEPTH - 1)
            d = LINE_DEPTH - 1;
         pos   = (hist_ptr + LINE_DEPTH - d) % LINE_DEPTH;
         acc_l += longint'(left_hist[pos]) * longint'(power);
         acc_r += longint'(right_hist[pos]) * longint'(power);
         power = (power * cfg_gain + 64'd16384) >> 15;
         if (power > 64'hFFFF_FFFF)
            power = 64'hFFFF_FFFF;
      end
      r.left_out  = q15_round_sat(acc_l);
      r.right_out = cfg_stereo ? q15_round_sat(acc_r) : it.right_in;
      hist_ptr    = (hist_ptr + 1) % LINE_DEPTH;
      return r;
   endfunction

   // Downstream back-pressure: random stall bursts while enabled.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run <= stall_run - 1;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_run <= $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare every accepted result with the oldest prediction.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_echoes.size() == 0) begin
            $error("unexpected result: left_out %0d right_out %0d",
                   rsp_item.left_out, rsp_item.right_out);
            error_count++;
         end else begin
            want = pending_echoes.pop_front();
            if (rsp_item.left_out !== want.left_out) begin
               $error("left_out mismatch: expected %0d, actual %0d",
                      want.left_out, rsp_item.left_out);
               error_count++;
            end
            if (rsp_item.right_out !== want.right_out) begin
               $error("right_out mismatch: expected %0d, actual %0d",
                      want.right_out, rsp_item.right_out);
               error_count++;
            end
         end
      end
   end

   // Present one item, hold it until taken, then maybe drop valid for a short gap.
   // Valid is left high otherwise so back-to-back items go out without a bubble.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] left,
                              input logic signed [SAMPLE_W-1:0] right);
      req_type it;
      it.left_in  = left;
      it.right_in = right;
      req_item  <= it;
      req_valid <= 1'b1;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      pending_echoes.insert(pending_echoes.size(), echo_predict(it));
      items_sent++;
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Drop valid, wait for every outstanding result, then let the pipeline go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_echoes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Drain the block, then write all four registers back to back; unused upper
   // data bits carry junk that the block must mask off.
   task automatic apply_settings(input int unsigned delay, input int unsigned count,
                                 input int unsigned gain, input bit stereo);
      logic [CSR_DATA_W-1:0] junk;
      settle();
      junk = CSR_DATA_W'($urandom);
      csr_we    <= 1'b1;
      csr_index <= CSR_DELAY_SAMPLES;
      csr_wdata <= {junk[15:14], delay[DELAY_W-1:0]};
      @(posedge clock);
      csr_index <= CSR_ECHO_COUNT;
      csr_wdata <= {junk[11:0], count[COUNT_W-1:0]};
      @(posedge clock);
      csr_index <= CSR_ECHO_GAIN;
      csr_wdata <= gain[GAIN_W-1:0];
      @(posedge clock);
      csr_index <= CSR_STEREO;
      csr_wdata <= {junk[14:0], stereo};
      @(posedge clock);
      csr_we     <= 1'b0;
      cfg_delay  = delay & 32'h3FFF;
      cfg_taps   = count & 32'hF;
      cfg_gain   = gain & 32'hFFFF;
      cfg_stereo = stereo;
   endtask

   // Mix of full-range noise, quiet signal, extremes and values around zero.
   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      logic [SAMPLE_W-1:0] v;
      v = SAMPLE_W'($urandom);
      case ($urandom_range(0, 9))
         0: v = 16'h7FFF;
         1: v = 16'h8000;
         2: v = SAMPLE_W'($urandom_range(0, 2) - 1);
         3, 4, 5: v = SAMPLE_W'($urandom_range(0, 4000) - 2000);
         default: ;
      endcase
      return v;
   endfunction

   // Registers at their reset values: taps land on the cleared line.
   task automatic test_reset_defaults();
      send_sample(32767, -32768);
      send_sample(-32768, 32767);
      send_sample(1, -1);
      send_sample(0, 0);
      settle();
   endtask

   // Adjacent taps at full gain and full scale: drive both saturation rails.
   task automatic test_saturation();
      apply_settings(1, 8, 65535, 1'b1);
      send_sample(32767, -32768);
      send_sample(32767, -32768);
      send_sample(-32768, 32767);
      apply_settings(1, 8, 0, 1'b1);
      send_sample(-32768, 32767);
      send_sample(12345, -12345);
      send_sample(-1, 1);
      settle();
   endtask

   // Zero spacing: every tap reads the item just written.
   task automatic test_zero_delay();
      apply_settings(0, 4, 32768, 1'b1);
      send_sample(100, -100);
      send_sample(-5000, 7000);
      send_sample(32767, -32768);
      settle();
   endtask

   // Tap count of zero passes the input through; counts above the limit clamp.
   task automatic test_tap_limits();
      apply_settings(2, 0, 40000, 1'b1);
      send_sample(20000, -20000);
      send_sample(-300, 300);
      apply_settings(2, 15, 24000, 1'b1);
      send_sample(1000, -1000);
      send_sample(-2000, 3000);
      settle();
   endtask

   // Multiples of the spacing that step past the line length must clamp,
   // not wrap round onto the newest items.
   task automatic test_line_end();
      apply_settings(8192, 3, 65535, 1'b1);
      send_sample(9000, -9000);
      apply_settings(5462, 4, 50000, 1'b1);
      send_sample(-15000, 15000);
      apply_settings(16383, 1, 32768, 1'b1);
      send_sample(4000, -4000);
      settle();
   endtask

   // Mono leaves the right history untouched: fill it, go mono, then read back.
   task automatic test_mono();
      apply_settings(1, 1, 32768, 1'b1);
      send_sample(1111, 2222);
      apply_settings(1, 2, 40000, 1'b0);
      send_sample(-3333, 4444);
      send_sample(5555, -6666);
      apply_settings(1, 3, 32768, 1'b1);
      send_sample(7, -7);
      send_sample(-8, 8);
      settle();
   endtask

   // Random phases: fresh settings, a run of items, drain, repeat.
   task automatic test_random_phases();
      int unsigned delay;
      int unsigned count;
      int unsigned gain;
      int          n;
      while (items_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: delay = 0;
            1: delay = 16383;
            2: delay = LINE_DEPTH / $urandom_range(2, 8) + $urandom_range(0, 2) - 1;
            3, 4: delay = $urandom_range(65, 16383);
            default: delay = $urandom_range(1, 64);
         endcase
         count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
         case ($urandom_range(0, 9))
            0: gain = 0;
            1: gain = 65535;
            2: gain = 32768;
            3: gain = 16384;
            default: gain = $urandom_range(0, 65535);
         endcase
         apply_settings(delay, count, gain, $urandom_range(0, 3) != 0);
         // Some phases run flat out on one or both sides.
         send_gaps   = $urandom_range(0, 3) != 0;
         sink_stalls = $urandom_range(0, 3) != 0;
         n = $urandom_range(20, 120);
         repeat (n) send_sample(random_sample(), random_sample());
         settle();
      end
   endtask

   // Closing stretch with no idling on either side.
   task automatic test_closing_burst();
      send_gaps   = 1'b0;
      sink_stalls = 1'b0;
      apply_settings($urandom_range(1, 32), $urandom_range(1, 8),
                     $urandom_range(0, 65535), 1'b1);
      repeat (BURST_ITEMS) send_sample(random_sample(), random_sample());
      settle();
   endtask

   initial begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
         left_hist[i]  = '0;
         right_hist[i] = '0;
      end
      hist_ptr   = 0;
      cfg_delay  = 32'(DELAY_RESET);
      cfg_taps   = 32'(COUNT_RESET);
      cfg_gain   = 32'(GAIN_RESET);
      cfg_stereo = STEREO_RESET;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The first item waits out the clearing pass on req_stall.
      send_gaps   = 1'b1;
      sink_stalls = 1'b1;
      test_reset_defaults();
      test_saturation();
      test_zero_delay();
      test_tap_limits();
      test_line_end();
      test_mono();
      test_random_phases();
      test_closing_burst();

      if (error_count == 0) begin
         $display("multitap_echo_core verification clean");
      end else begin
         $display("multitap_echo_core verification failed");
      end
      $finish;
   end

endmodule

// ----- multitap_echo_core.f -----
rtl/core/mte_pkg.sv
rtl/core/mte_seq.sv
rtl/core/multitap_echo_core.sv
tb/sv/tb.sv
